// ----- hw/rtl/obh_pkg.sv -----
// Shared widths, register indexes and word types for the oriented box ray test.
// Used by every module of ray_oriented_box_hit; depends on nothing.
package obh_pkg;

  localparam int CW = 32;              // coordinate width
  localparam int FB = 16;              // fraction bits of coordinates
  localparam int AW = 18;              // angle register width
  localparam int AF = 16;              // fraction bits of the angle registers
  localparam int NREG = 8;
  localparam int ADDR_W = $clog2(NREG);
  localparam int NSLAB = 4;
  localparam int NEXT = 4;

  localparam int DW = CW + 1;          // start point minus center
  localparam int PROD_W = DW + AW;
  localparam int SUM_W = PROD_W + 1;
  localparam int P_W = SUM_W - AF;     // local coordinates after rotation
  localparam int N_W = P_W + 1;        // extent minus local start
  localparam int NUM_W = N_W + FB;     // dividend
  localparam int DEN_W = P_W;          // divisor magnitude
  localparam int Q_W = NUM_W;          // quotient
  localparam int REM_W = DEN_W + 1;
  localparam int DIV_SPS = 2;          // quotient bits per divider stage
  localparam int DIV_STAGES = (NUM_W + DIV_SPS - 1) / DIV_SPS;

  localparam int MA_LO = DEN_W / 2;
  localparam int MA_HI = DEN_W - MA_LO;
  localparam int MQ_LO = (Q_W + 1) / 2;
  localparam int MQ_HI = Q_W - MQ_LO;
  localparam int FULL_W = DEN_W + Q_W;
  localparam int H_W = P_W + 2;

  localparam int G_W = CW + 1;         // grown extent
  localparam int GROW_SHIFT = CW + 13;
  localparam longint unsigned GROW_DIV = 64'd10000;
  localparam logic [CW-1:0] GROW_MUL =
    CW'(((64'd1 << GROW_SHIFT) + GROW_DIV - 64'd1) / GROW_DIV);

  localparam int OUT_W = CW - 1;

  // Extent slots inside the box word.
  localparam int EXT_XL = 0;
  localparam int EXT_XH = 1;
  localparam int EXT_YL = 2;
  localparam int EXT_YH = 3;

  typedef enum logic [ADDR_W-1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_COS,
    REG_SIN,
    REG_EXT_XL,
    REG_EXT_XH,
    REG_EXT_YL,
    REG_EXT_YH
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] center_x;
    logic signed [CW-1:0] center_y;
    logic signed [AW-1:0] cos_a;
    logic signed [AW-1:0] sin_a;
    logic [NEXT-1:0][CW-1:0] ext;
    logic [NEXT-1:0][G_W-1:0] grown;
  } box_t;

  // What travels beside one slab division.
  typedef struct packed {
    logic cand;
    logic neg;
    logic [DEN_W-1:0] amag;
    logic signed [P_W-1:0] p_oth;
  } slab_tag_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    slab_tag_t tag;
  } slab_in_t;

endpackage

// ----- hw/rtl/obh_cfg.sv -----
// Configuration registers of the box and the grown extents derived from them.
// Depends on obh_pkg.
module obh_cfg (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [obh_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [obh_pkg::CW-1:0] cfg_wdata,
  output obh_pkg::box_t box
);
  import obh_pkg::*;

  logic [CW-1:0] center_x_r, center_y_r;
  logic [AW-1:0] cos_r, sin_r;
  logic [NEXT-1:0][CW-1:0] ext_r;
  logic [NEXT-1:0][2*CW-1:0] prod_r, prod_nxt;
  logic [NEXT-1:0][G_W-1:0] grown_r, grown_nxt;
  logic [NEXT-1:0][CW-1:0] mag;
  logic [NEXT-1:0][2*CW-GROW_SHIFT-1:0] quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      cos_r <= AW'(1 << AF);
      sin_r <= '0;
      ext_r <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        REG_COS:      cos_r <= cfg_wdata[AW-1:0];
        REG_SIN:      sin_r <= cfg_wdata[AW-1:0];
        REG_EXT_XL:   ext_r[EXT_XL] <= cfg_wdata;
        REG_EXT_XH:   ext_r[EXT_XH] <= cfg_wdata;
        REG_EXT_YL:   ext_r[EXT_YL] <= cfg_wdata;
        REG_EXT_YH:   ext_r[EXT_YH] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Grown extent e + e / 10000, the quotient truncated toward zero by a reciprocal multiply on the magnitude.
  always_comb begin
    for (int i = 0; i < NEXT; i++) begin
      mag[i] = ext_r[i][CW-1] ? (~ext_r[i] + CW'(1)) : ext_r[i];
      prod_nxt[i] = (2*CW)'(mag[i]) * (2*CW)'(GROW_MUL);
      quo[i] = prod_r[i][2*CW-1:GROW_SHIFT];
      grown_nxt[i] = ext_r[i][CW-1] ? ({ext_r[i][CW-1], ext_r[i]} - G_W'(quo[i]))
                                     : ({ext_r[i][CW-1], ext_r[i]} + G_W'(quo[i]));
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    grown_r <= grown_nxt;
  end

  assign box.center_x = center_x_r;
  assign box.center_y = center_y_r;
  assign box.cos_a = cos_r;
  assign box.sin_a = sin_r;
  assign box.ext = ext_r;
  assign box.grown = grown_r;

endmodule

// ----- hw/rtl/obh_front.sv -----
// Front stages: move the ray into the box frame and set up the four slab divisions.
// Depends on obh_pkg.
module obh_front (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [obh_pkg::CW-1:0] ray_x,
  input  logic [obh_pkg::CW-1:0] ray_y,
  input  logic [obh_pkg::CW-1:0] step_x,
  input  logic [obh_pkg::CW-1:0] step_y,
  input  obh_pkg::box_t box,
  output logic vld_o,
  output obh_pkg::slab_in_t [obh_pkg::NSLAB-1:0] slab_o
);
  import obh_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  logic signed [DW-1:0] dx_r, dy_r;
  logic signed [CW-1:0] sx_r, sy_r;
  logic signed [PROD_W-1:0] dxc_r, dxs_r, dyc_r, dys_r, sxc_r, sxs_r, syc_r, sys_r;
  logic signed [SUM_W-1:0] px_sum, py_sum, vx_sum, vy_sum;
  logic signed [P_W-1:0] px_r, py_r, vx_r, vy_r;
  slab_in_t [NSLAB-1:0] slab_nxt, slab_r;

  function automatic slab_in_t prep(input logic signed [CW-1:0] e,
                                    input logic signed [G_W-1:0] glo,
                                    input logic signed [G_W-1:0] ghi,
                                    input logic signed [P_W-1:0] p,
                                    input logic signed [P_W-1:0] d,
                                    input logic signed [P_W-1:0] po,
                                    input logic signed [P_W-1:0] dd);
    logic signed [N_W-1:0] n;
    logic [N_W-1:0] nmag;
    logic inr;
    slab_in_t r;
    n = N_W'(e) - N_W'(p);
    nmag = n[N_W-1] ? N_W'(-n) : N_W'(n);
    inr = (G_W'(e) >= glo) && (G_W'(e) <= ghi);
    r.num = {nmag, {FB{1'b0}}};
    r.den = d[P_W-1] ? DEN_W'(-d) : DEN_W'(d);
    r.tag.cand = (d != '0) && (n != '0) && (n[N_W-1] == d[P_W-1]) && inr;
    r.tag.neg = dd[P_W-1];
    r.tag.amag = dd[P_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
    r.tag.p_oth = po;
    return r;
  endfunction

  // Products are formed in full; the floor shift is the upper slice of the sum.
  always_comb begin
    px_sum = SUM_W'(dxc_r) + SUM_W'(dys_r);
    py_sum = SUM_W'(dyc_r) - SUM_W'(dxs_r);
    vx_sum = SUM_W'(sxc_r) + SUM_W'(sys_r);
    vy_sum = SUM_W'(syc_r) - SUM_W'(sxs_r);
    slab_nxt[0] = prep(box.ext[EXT_XL], box.grown[EXT_XL], box.grown[EXT_XH],
                       px_r, vx_r, py_r, vy_r);
    slab_nxt[1] = prep(box.ext[EXT_XH], box.grown[EXT_XL], box.grown[EXT_XH],
                       px_r, vx_r, py_r, vy_r);
    slab_nxt[2] = prep(box.ext[EXT_YH], box.grown[EXT_YL], box.grown[EXT_YH],
                       py_r, vy_r, px_r, vx_r);
    slab_nxt[3] = prep(box.ext[EXT_YL], box.grown[EXT_YL], box.grown[EXT_YH],
                       py_r, vy_r, px_r, vx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DW'($signed(ray_x)) - DW'(box.center_x);
      dy_r <= DW'($signed(ray_y)) - DW'(box.center_y);
      sx_r <= $signed(step_x);
      sy_r <= $signed(step_y);
      dxc_r <= PROD_W'(dx_r) * PROD_W'(box.cos_a);
      dxs_r <= PROD_W'(dx_r) * PROD_W'(box.sin_a);
      dyc_r <= PROD_W'(dy_r) * PROD_W'(box.cos_a);
      dys_r <= PROD_W'(dy_r) * PROD_W'(box.sin_a);
      sxc_r <= PROD_W'(sx_r) * PROD_W'(box.cos_a);
      sxs_r <= PROD_W'(sx_r) * PROD_W'(box.sin_a);
      syc_r <= PROD_W'(sy_r) * PROD_W'(box.cos_a);
      sys_r <= PROD_W'(sy_r) * PROD_W'(box.sin_a);
      px_r <= px_sum[SUM_W-1:AF];
      py_r <= py_sum[SUM_W-1:AF];
      vx_r <= vx_sum[SUM_W-1:AF];
      vy_r <= vy_sum[SUM_W-1:AF];
      slab_r <= slab_nxt;
    end
  end

  assign vld_o = v4_r;
  assign slab_o = slab_r;

endmodule

// ----- hw/rtl/obh_div.sv -----
// Pipelined restoring divider for one slab distance, DIV_SPS quotient bits a stage.
// Depends on obh_pkg; the slab tag rides along unchanged.
module obh_div (
  input  logic clk,
  input  logic en,
  input  obh_pkg::slab_in_t slab_i,
  output logic [obh_pkg::Q_W-1:0] q_o,
  output obh_pkg::slab_tag_t tag_o
);
  import obh_pkg::*;

  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [NUM_W-1:0] nq_r [DIV_STAGES];
  logic [DEN_W-1:0] den_r [DIV_STAGES];
  slab_tag_t tag_r [DIV_STAGES];
  logic [REM_W-1:0] rem_nxt [DIV_STAGES];
  logic [NUM_W-1:0] nq_nxt [DIV_STAGES];

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_comb begin
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] nq;
    logic [DEN_W-1:0] den;
    for (int i = 0; i < DIV_STAGES; i++) begin
      rem = (i == 0) ? '0 : rem_r[(i == 0) ? 0 : i - 1];
      nq = (i == 0) ? slab_i.num : nq_r[(i == 0) ? 0 : i - 1];
      den = (i == 0) ? slab_i.den : den_r[(i == 0) ? 0 : i - 1];
      for (int k = 0; k < DIV_SPS; k++) begin
        if (i * DIV_SPS + k < NUM_W) begin
          rem = {rem[REM_W-2:0], nq[NUM_W-1]};
          nq = {nq[NUM_W-2:0], 1'b0};
          if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            nq[0] = 1'b1;
          end
        end
      end
      rem_nxt[i] = rem;
      nq_nxt[i] = nq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < DIV_STAGES; i++) begin
        rem_r[i] <= rem_nxt[i];
        nq_r[i] <= nq_nxt[i];
        den_r[i] <= (i == 0) ? slab_i.den : den_r[(i == 0) ? 0 : i - 1];
        tag_r[i] <= (i == 0) ? slab_i.tag : tag_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign q_o = nq_r[DIV_STAGES-1];
  assign tag_o = tag_r[DIV_STAGES-1];

endmodule

// ----- hw/rtl/obh_back.sv -----
// Back stages: hit point test on the other axis, minimum of kept distances, output word.
// Depends on obh_pkg.
module obh_back (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic vld_i,
  input  logic [obh_pkg::NSLAB-1:0][obh_pkg::Q_W-1:0] q_i,
  input  obh_pkg::slab_tag_t [obh_pkg::NSLAB-1:0] tag_i,
  input  obh_pkg::box_t box,
  output logic vld_o,
  output logic hit_o,
  output logic [obh_pkg::OUT_W-1:0] dist_o
);
  import obh_pkg::*;

  localparam logic [Q_W-1:0] DMAX = Q_W'({OUT_W{1'b1}});

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [NSLAB-1:0][MA_LO+MQ_LO-1:0] ll_r;
  logic [NSLAB-1:0][MA_LO+MQ_HI-1:0] lh_r;
  logic [NSLAB-1:0][MA_HI+MQ_LO-1:0] hl_r;
  logic [NSLAB-1:0][MA_HI+MQ_HI-1:0] hh_r;
  logic [NSLAB-1:0][Q_W-1:0] q1_r, q2_r, q3_r;
  slab_tag_t [NSLAB-1:0] t1_r, t2_r;
  logic [NSLAB-1:0] ok1_r, ok2_r, keep_r;
  logic [NSLAB-1:0] big_r;
  logic [NSLAB-1:0][P_W-1:0] m_r;
  logic [NSLAB-1:0][FULL_W-1:0] full;
  logic [NSLAB-1:0][H_W-1:0] h;
  logic [NSLAB-1:0] keep_nxt;
  logic [1:0] pf_r;
  logic [1:0][Q_W-1:0] pb_r;
  logic [1:0] pf_nxt;
  logic [1:0][Q_W-1:0] pb_nxt;
  logic hit_nxt;
  logic [Q_W-1:0] best_nxt;
  logic hit_r;
  logic [OUT_W-1:0] dist_r;

  always_comb begin
    logic signed [G_W-1:0] lo, hi;
    for (int k = 0; k < NSLAB; k++) begin
      full[k] = FULL_W'(ll_r[k]) + (FULL_W'(lh_r[k]) << MQ_LO)
              + (FULL_W'(hl_r[k]) << MA_LO) + (FULL_W'(hh_r[k]) << (MA_LO + MQ_LO));
      h[k] = t2_r[k].neg ? (H_W'(t2_r[k].p_oth) - H_W'(m_r[k]))
                         : (H_W'(t2_r[k].p_oth) + H_W'(m_r[k]));
      // The x slabs test the hit point against y bounds and the other way round.
      lo = (k < 2) ? box.grown[EXT_YL] : box.grown[EXT_XL];
      hi = (k < 2) ? box.grown[EXT_YH] : box.grown[EXT_XH];
      keep_nxt[k] = ok2_r[k] && !big_r[k] && ($signed(h[k]) >= H_W'(lo))
                    && ($signed(h[k]) <= H_W'(hi));
    end
    for (int j = 0; j < 2; j++) begin
      pf_nxt[j] = keep_r[2*j] || keep_r[2*j+1];
      if (keep_r[2*j] && (!keep_r[2*j+1] || q3_r[2*j] < q3_r[2*j+1])) begin
        pb_nxt[j] = q3_r[2*j];
      end else begin
        pb_nxt[j] = q3_r[2*j+1];
      end
    end
    hit_nxt = pf_r[0] || pf_r[1];
    if (pf_r[0] && (!pf_r[1] || pb_r[0] < pb_r[1])) begin
      best_nxt = pb_r[0];
    end else if (pf_r[1]) begin
      best_nxt = pb_r[1];
    end else begin
      best_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NSLAB; k++) begin
        ll_r[k] <= (MA_LO+MQ_LO)'(tag_i[k].amag[MA_LO-1:0]) * (MA_LO+MQ_LO)'(q_i[k][MQ_LO-1:0]);
        lh_r[k] <= (MA_LO+MQ_HI)'(tag_i[k].amag[MA_LO-1:0])
                   * (MA_LO+MQ_HI)'(q_i[k][Q_W-1:MQ_LO]);
        hl_r[k] <= (MA_HI+MQ_LO)'(tag_i[k].amag[DEN_W-1:MA_LO])
                   * (MA_HI+MQ_LO)'(q_i[k][MQ_LO-1:0]);
        hh_r[k] <= (MA_HI+MQ_HI)'(tag_i[k].amag[DEN_W-1:MA_LO])
                   * (MA_HI+MQ_HI)'(q_i[k][Q_W-1:MQ_LO]);
        q1_r[k] <= q_i[k];
        t1_r[k] <= tag_i[k];
        ok1_r[k] <= tag_i[k].cand && (q_i[k] != '0);
        m_r[k] <= full[k][FB +: P_W];
        big_r[k] <= |full[k][FULL_W-1:FB+P_W];
        q2_r[k] <= q1_r[k];
        t2_r[k] <= t1_r[k];
        ok2_r[k] <= ok1_r[k];
        q3_r[k] <= q2_r[k];
      end
      keep_r <= keep_nxt;
      pf_r <= pf_nxt;
      pb_r <= pb_nxt;
      hit_r <= hit_nxt;
      dist_r <= (best_nxt > DMAX) ? {OUT_W{1'b1}} : best_nxt[OUT_W-1:0];
    end
  end

  assign vld_o = v5_r;
  assign hit_o = hit_r;
  assign dist_o = dist_r;

endmodule

// ----- hw/rtl/ray_oriented_box_hit.sv -----
// Ray against rotated box: an accepted input word passes through 4 front stages,
// DIV_STAGES = 27 divider stages and 5 back stages on the way to its result word.
// Throughput one word per cycle; the whole pipeline holds when the output word
// waits, so in_ready follows out_ready whenever a result is pending.
// Synchronous active-low reset clears all valid bits and loads the reset box.
module ray_oriented_box_hit (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [obh_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [obh_pkg::CW-1:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic [obh_pkg::CW-1:0] in_ray_x,
  input  logic [obh_pkg::CW-1:0] in_ray_y,
  input  logic [obh_pkg::CW-1:0] in_step_x,
  input  logic [obh_pkg::CW-1:0] in_step_y,
  output logic out_valid,
  input  logic out_ready,
  output logic out_hit,
  output logic [obh_pkg::OUT_W-1:0] out_distance
);
  import obh_pkg::*;

  box_t box;
  logic en;
  logic front_vld;
  slab_in_t [NSLAB-1:0] slab;
  logic [NSLAB-1:0][Q_W-1:0] q;
  slab_tag_t [NSLAB-1:0] tag;
  logic [DIV_STAGES-1:0] dvld_r;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  obh_cfg u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .box(box)
  );

  obh_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(in_valid && in_ready),
    .ray_x(in_ray_x), .ray_y(in_ray_y), .step_x(in_step_x), .step_y(in_step_y),
    .box(box), .vld_o(front_vld), .slab_o(slab)
  );

  for (genvar k = 0; k < NSLAB; k++) begin : g_div
    obh_div u_div (
      .clk(clk), .en(en), .slab_i(slab[k]), .q_o(q[k]), .tag_o(tag[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[DIV_STAGES-2:0], front_vld};
    end
  end

  obh_back u_back (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_i(dvld_r[DIV_STAGES-1]),
    .q_i(q), .tag_i(tag), .box(box),
    .vld_o(out_valid), .hit_o(out_hit), .dist_o(out_distance)
  );

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_distance == '0)
    else $error("miss word carries a nonzero distance");

  a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_distance != '0)
    else $error("hit word carries a zero distance");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

// ----- dv/tb_ray_oriented_box_hit.sv -----
// Testbench for ray_oriented_box_hit: a predictor of the rotated box ray test
// checks every result word in order. Depends on obh_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_ray_oriented_box_hit;
  import obh_pkg::*;

  localparam longint LIM = 64'sd1 << 37;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CW-1:0] in_ray_x = '0, in_ray_y = '0, in_step_x = '0, in_step_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;
  logic [OUT_W-1:0] out_distance;

  typedef struct {
    logic hit;
    logic [OUT_W-1:0] distance;
  } hit_word_t;

  hit_word_t pending_hits[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;

  // Register image kept by the testbench.
  longint box_cx, box_cy, box_cos, box_sin, ext_xl, ext_xh, ext_yl, ext_yh;

  ray_oriented_box_hit i_dut (.*);

  always #1 clk = ~clk;

  function automatic longint clip37(longint v);
    if (v > LIM) return LIM;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic longint absval(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Floor of v / 2^16 (arithmetic shift already floors).
  function automatic longint rot_shift(longint v);
    return v >>> 16;
  endfunction

  function automatic longint grown_ext(longint e);
    return e + e / 10000;
  endfunction

  function automatic void slab_try(longint ext, longint pm, longint dm,
                                   longint po, longint d_o,
                                   longint gml, longint gmh, longint gol, longint goh,
                                   ref bit found, ref longint unsigned best);
    longint n, h;
    longint unsigned q, m;
    logic [127:0] prod;
    if (dm == 0) return;
    n = ext - pm;
    if (n == 0 || ((n > 0) != (dm > 0))) return;
    q = (longint'(absval(n)) << FB) / longint'(absval(dm));
    if (q == 0) return;
    if (ext < gml || ext > gmh) return;
    prod = (128'(absval(d_o)) * 128'(q)) >> FB;
    m = (prod > (128'd1 << 62)) ? (64'd1 << 62) : prod[63:0];
    h = (d_o < 0) ? po - longint'(m) : po + longint'(m);
    if (h < gol || h > goh) return;
    if (!found || q < best) begin
      found = 1'b1;
      best = q;
    end
  endfunction

  function automatic hit_word_t predict_hit(logic [CW-1:0] rx, ry, sx0, sy0);
    hit_word_t r;
    longint dx, dy, sx, sy, px, py, vx, vy, xl, xh, yl, yh;
    bit found;
    longint unsigned best;
    found = 1'b0;
    best = 0;
    xl = clip37(ext_xl); xh = clip37(ext_xh);
    yl = clip37(ext_yl); yh = clip37(ext_yh);
    dx = clip37(longint'(signed'(rx)) - box_cx);
    dy = clip37(longint'(signed'(ry)) - box_cy);
    sx = clip37(longint'(signed'(sx0)));
    sy = clip37(longint'(signed'(sy0)));
    px = clip37(rot_shift(dx * box_cos + dy * box_sin));
    py = clip37(rot_shift(dy * box_cos - dx * box_sin));
    vx = clip37(rot_shift(sx * box_cos + sy * box_sin));
    vy = clip37(rot_shift(sy * box_cos - sx * box_sin));
    slab_try(xl, px, vx, py, vy, grown_ext(xl), grown_ext(xh), grown_ext(yl),
             grown_ext(yh), found, best);
    slab_try(xh, px, vx, py, vy, grown_ext(xl), grown_ext(xh), grown_ext(yl),
             grown_ext(yh), found, best);
    slab_try(yh, py, vy, px, vx, grown_ext(yl), grown_ext(yh), grown_ext(xl),
             grown_ext(xh), found, best);
    slab_try(yl, py, vy, px, vx, grown_ext(yl), grown_ext(yh), grown_ext(xl),
             grown_ext(xh), found, best);
    r.hit = found;
    r.distance = !found ? '0 : (best > 64'h7fffffff ? '1 : OUT_W'(best));
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_CENTER_X: box_cx = longint'(signed'(val));
      REG_CENTER_Y: box_cy = longint'(signed'(val));
      REG_COS:      box_cos = longint'(signed'(val[AW-1:0]));
      REG_SIN:      box_sin = longint'(signed'(val[AW-1:0]));
      REG_EXT_XL:   ext_xl = longint'(signed'(val));
      REG_EXT_XH:   ext_xh = longint'(signed'(val));
      REG_EXT_YL:   ext_yl = longint'(signed'(val));
      default:      ext_yh = longint'(signed'(val));
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Drops the input valid and waits for the pipeline to drain before touching
  // the registers.
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic set_box(longint cx, cy, c, s, xl, xh, yl, yh);
    drain_pipe();
    write_reg(REG_CENTER_X, CW'(cx));
    write_reg(REG_CENTER_Y, CW'(cy));
    write_reg(REG_COS, CW'(c));
    write_reg(REG_SIN, CW'(s));
    write_reg(REG_EXT_XL, CW'(xl));
    write_reg(REG_EXT_XH, CW'(xh));
    write_reg(REG_EXT_YL, CW'(yl));
    write_reg(REG_EXT_YH, CW'(yh));
  endtask

  // Valid stays high after an accepted word until the next word or an idle cycle.
  task automatic send_ray(logic [CW-1:0] rx, ry, sx, sy);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ray_x <= rx;
    in_ray_y <= ry;
    in_step_x <= sx;
    in_step_y <= sy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_hits.push_back(predict_hit(rx, ry, sx, sy));
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return CW'(int'($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  task automatic test_directed();
    set_box(0, 0, 65536, 0, -(4 << 16), 4 << 16, -(2 << 16), 2 << 16);
    send_ray(-(10 << 16), 0, 1 << 16, 0);
    send_ray(10 << 16, 0, -(1 << 16), 0);
    send_ray(0, -(10 << 16), 0, 1 << 16);
    send_ray(0, 10 << 16, 0, -(1 << 16));
    send_ray(0, 0, 1 << 16, 1 << 16);
    send_ray(0, 0, 0, 0);
    send_ray(-(10 << 16), 0, -(1 << 16), 0);
    send_ray(-(10 << 16), 0, 1, 0);
    send_ray(-(10 << 16), 0, 32'h7fffffff, 0);
    send_ray(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_ray(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
    send_ray(4 << 16, 2 << 16, 1 << 16, 0);
    send_ray(-(10 << 16), (2 << 16) + 13, 1 << 16, 0);
    // Low above high leaves nothing inside the box.
    set_box(0, 0, 65536, 0, 4 << 16, -(4 << 16), -(2 << 16), 2 << 16);
    send_ray(-(10 << 16), 0, 1 << 16, 0);
    // Box away from its own origin, rotated by a right angle.
    set_box(3 << 16, -(5 << 16), 0, 65536, 1 << 16, 3 << 16, 1 << 16, 3 << 16);
    send_ray(0, 0, 1 << 16, 0);
    send_ray(0, 0, 0, -(1 << 16));
    set_box(32'h7fffffff, 32'h80000000, -65536, 0, 32'h80000000, 32'h7fffffff,
            32'h80000000, 32'h7fffffff);
    send_ray(0, 0, 1, 1);
    send_ray(32'hffffffff, 32'hffffffff, 32'hffffffff, 1);
  endtask

  task automatic test_random();
    longint c, s;
    for (int blk = 0; blk < 10; blk++) begin
      c = int'($urandom_range(131072)) - 65536;
      s = int'($urandom_range(131072)) - 65536;
      if (blk == 0) begin c = 65536; s = 0; end
      if (blk == 1) begin c = -65536; s = 0; end
      if (blk == 2) begin c = 46341; s = -46341; end
      if (blk == 9) begin
        set_box(rand_coord(), rand_coord(), c, s, rand_coord(), rand_coord(),
                rand_coord(), rand_coord());
      end else begin
        set_box(int'($urandom_range(20 << 16)) - (10 << 16),
                int'($urandom_range(20 << 16)) - (10 << 16), c, s,
                -longint'($urandom_range(8 << 16)), $urandom_range(8 << 16),
                -longint'($urandom_range(8 << 16)), $urandom_range(8 << 16));
      end
      calm = (blk == 4);
      for (int k = 0; k < 143; k++)
        send_ray(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      calm = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  always @(posedge clk) begin
    hit_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word: hit %0b dist %0d",
                                   out_hit, out_distance);
      end else begin
        exp_w = pending_hits.pop_front();
        if (out_hit !== exp_w.hit || out_distance !== exp_w.distance) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected hit %0b dist %0d, got hit %0b dist %0d",
                     exp_w.hit, exp_w.distance, out_hit, out_distance);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    box_cx = 0; box_cy = 0; box_cos = 65536; box_sin = 0;
    ext_xl = 0; ext_xh = 0; ext_yl = 0; ext_yh = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // The reset box is degenerate but still worth a few words.
    send_ray(-(1 << 16), 0, 1 << 16, 0);
    send_ray(0, 0, 1 << 16, 0);
    test_directed();
    test_random();
    drain_pipe();
    if (errors == 0 && pending_hits.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
